### sv/fpnc_pkg.sv
`default_nettype none

package fpnc_pkg;

    // default sizes
    localparam int MAX_STATES_DEF = 64;
    localparam int NODE_COUNT_DEF = 256;

    // state count after reset
    localparam logic [6:0] NUM_STATES_RESET = 7'd4;

    // saturation limits
    localparam logic [23:0] SITE_MAX  = 24'hFF_FFFF;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // one input word: two children, destination, weight, root flag
    typedef struct packed {
        logic        left_is_leaf;
        logic [6:0]  left_char;
        logic [7:0]  left_node;
        logic        right_is_leaf;
        logic [6:0]  right_char;
        logic [7:0]  right_node;
        logic [7:0]  dest_node;
        logic [15:0] weight;
        logic        site_end;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [63:0] node_set;
        logic [15:0] step_cost;
        logic [23:0] site_score;
        logic [31:0] total_score;
        logic        site_done;
    } out_word_t;

    // node index modulo the store depth, by reciprocal multiplication
    // recip is ceil(2^16 / count); exact for any 8-bit index when count < 256
    function automatic logic [7:0] node_mod(input logic [7:0] v, input logic [12:0] count,
                                            input logic [16:0] recip);
        logic [24:0] prod;
        logic [20:0] back;
        if (count > 13'd255) return v;
        prod = 25'(v) * 25'(recip);
        back = 21'(prod[23:16]) * 21'(count);
        return v - back[7:0];
    endfunction

endpackage

`default_nettype wire

### sv/fitch_parsimony_node_combine.sv
`default_nettype none

// Fitch small-parsimony merge, one site at a time. Each input word names two
// children (leaf character or stored node set) and a destination node; the block
// intersects the two sets, falls back to the union and charges the word's weight
// when the intersection is empty, stores the merged set at the destination and
// returns the set with the step cost, the running site score and the saturating
// total score. A word with site_end set closes the site and clears the site score
// afterwards. The user must write num_states through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce it. The block takes one word per
// cycle while the result side does not stall; the node store read is registered
// with the word on acceptance, and the merge feeds the result register when stage
// one advances. A word whose child was written by the word just before it is
// served by a forwarding path, so there is no stall between dependent words.
// Node indices are reduced modulo NODE_COUNT. A stored node must be written before
// it is read; no clearing of the store happens after reset.
module fitch_parsimony_node_combine
    import fpnc_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_word,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_word
);

    localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NODE_RECIP = (NODE_COUNT < 256) ? (65536 + NODE_COUNT - 1) / NODE_COUNT : 0;

    // node store
    logic [MAX_STATES-1:0] node_mem [NODE_COUNT];

    logic [6:0]            num_states_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    in_word_t              s1_word_reg;
    logic [NODE_W-1:0]     s1_left_idx_reg;
    logic [NODE_W-1:0]     s1_right_idx_reg;
    logic [NODE_W-1:0]     s1_dest_idx_reg;
    logic [MAX_STATES-1:0] rd_left_reg;
    logic [MAX_STATES-1:0] rd_right_reg;
    logic                  fwd_valid_reg;
    logic [NODE_W-1:0]     fwd_addr_reg;
    logic [MAX_STATES-1:0] fwd_data_reg;
    logic [23:0]           site_accum_reg;
    logic [23:0]           site_accum_next;
    logic [31:0]           total_accum_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_word_t             m_word_reg;

    logic                  s_accept;
    logic                  s1_advance;
    logic [NODE_W-1:0]     left_idx;
    logic [NODE_W-1:0]     right_idx;
    logic [NODE_W-1:0]     dest_idx;
    logic [MAX_STATES-1:0] left_stored;
    logic [MAX_STATES-1:0] right_stored;
    out_word_t             result;

    // handshake
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_word     = m_word_reg;

    // node indices modulo store depth
    assign left_idx  = NODE_W'(node_mod(s_word.left_node, 13'(NODE_COUNT), 17'(NODE_RECIP)));
    assign right_idx = NODE_W'(node_mod(s_word.right_node, 13'(NODE_COUNT), 17'(NODE_RECIP)));
    assign dest_idx  = NODE_W'(node_mod(s_word.dest_node, 13'(NODE_COUNT), 17'(NODE_RECIP)));

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_states_reg <= NUM_STATES_RESET;
        end else if (cfg_we) begin
            num_states_reg <= cfg_wdata;
        end
    end

    // store reads on accept, write when the merge leaves stage one
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_left_reg  <= node_mem[left_idx];
            rd_right_reg <= node_mem[right_idx];
        end
        if (s1_advance) begin
            node_mem[s1_dest_idx_reg] <= result.node_set[MAX_STATES-1:0];
        end
    end

    // stage one word register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_word_reg      <= s_word;
            s1_left_idx_reg  <= left_idx;
            s1_right_idx_reg <= right_idx;
            s1_dest_idx_reg  <= dest_idx;
            fwd_addr_reg     <= s1_dest_idx_reg;
            fwd_data_reg     <= result.node_set[MAX_STATES-1:0];
        end
    end

    // forward a write that lands on the same edge as the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= s1_advance;
        end
    end

    assign left_stored  = (fwd_valid_reg && (fwd_addr_reg == s1_left_idx_reg))
                        ? fwd_data_reg : rd_left_reg;
    assign right_stored = (fwd_valid_reg && (fwd_addr_reg == s1_right_idx_reg))
                        ? fwd_data_reg : rd_right_reg;

    // merge and scoring
    fpnc_merge #(
        .MAX_STATES (MAX_STATES)
    ) u_merge (
        .num_states   (num_states_reg),
        .item         (s1_word_reg),
        .left_stored  (left_stored),
        .right_stored (right_stored),
        .site_accum   (site_accum_reg),
        .total_accum  (total_accum_reg),
        .result       (result)
    );

    // control next values
    always_comb begin
        s1_valid_next   = s_accept || (s1_valid_reg && !s1_advance);
        m_valid_next    = s1_advance || (m_valid_reg && !m_ready);
        site_accum_next = s1_word_reg.site_end ? 24'd0 : result.site_score;
    end

    // control state and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            site_accum_reg  <= 24'd0;
            total_accum_reg <= 32'd0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_advance) begin
                site_accum_reg  <= site_accum_next;
                total_accum_reg <= result.total_score;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_word_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // total score never decreases
    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> total_accum_reg >= $past(total_accum_reg))
        else $error("total score decreased");

    // root merge clears the site score
    a_site_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && s1_word_reg.site_end |=> site_accum_reg == 24'd0)
        else $error("site score not cleared after root merge");

    // merged set stays inside the state width
    a_set_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_word_reg.node_set >> MAX_STATES) == 64'd0)
        else $error("node set has bits beyond the state width");

    // a held result is not overwritten by stage one
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s1_advance)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

### sv/fpnc_merge.sv
`default_nettype none

module fpnc_merge
    import fpnc_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  wire logic [6:0]            num_states,
    input  wire in_word_t              item,
    input  wire logic [MAX_STATES-1:0] left_stored,
    input  wire logic [MAX_STATES-1:0] right_stored,
    input  wire logic [23:0]           site_accum,
    input  wire logic [31:0]           total_accum,
    output out_word_t                  result
);

    logic [MAX_STATES-1:0] all_mask;
    logic [MAX_STATES-1:0] left_set;
    logic [MAX_STATES-1:0] right_set;
    logic [MAX_STATES-1:0] meet;
    logic [MAX_STATES-1:0] merged;
    logic [15:0]           cost;
    logic [24:0]           site_sum;
    logic [32:0]           total_sum;
    logic                  left_all;
    logic                  right_all;

    // every state in use: low min(num_states, MAX_STATES) bits
    always_comb begin
        for (int k = 0; k < MAX_STATES; k++) begin
            all_mask[k] = (8'(k) < {1'b0, num_states});
        end
    end

    // gap or out-of-range character stands for every state
    assign left_all  = (item.left_char >= num_states)
                    || ({1'b0, item.left_char} >= 8'(MAX_STATES));
    assign right_all = (item.right_char >= num_states)
                    || ({1'b0, item.right_char} >= 8'(MAX_STATES));

    // child sets
    always_comb begin
        for (int k = 0; k < MAX_STATES; k++) begin
            left_set[k]  = item.left_is_leaf
                ? (left_all ? all_mask[k] : (item.left_char == 7'(k)))
                : (left_stored[k] & all_mask[k]);
            right_set[k] = item.right_is_leaf
                ? (right_all ? all_mask[k] : (item.right_char == 7'(k)))
                : (right_stored[k] & all_mask[k]);
        end
    end

    // intersection, union when empty
    assign meet   = left_set & right_set;
    assign merged = (meet == '0) ? (left_set | right_set) : meet;
    assign cost   = (meet == '0) ? item.weight : 16'd0;

    // saturating scores
    assign site_sum  = {1'b0, site_accum} + 25'(cost);
    assign total_sum = {1'b0, total_accum} + 33'(cost);

    always_comb begin
        result.node_set    = 64'(merged);
        result.step_cost   = cost;
        result.site_score  = site_sum[24] ? SITE_MAX : site_sum[23:0];
        result.total_score = total_sum[32] ? TOTAL_MAX : total_sum[31:0];
        result.site_done   = item.site_end;
    end

endmodule

`default_nettype wire

### bench/fitch_score_checker.sv
`timescale 1ns / 100ps

module fitch_score_checker
    import fpnc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_word_t  s_word,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_word_t m_word,
    output int             mismatch_count,
    output int             results_due
);

    // shadow copy of the node sets, scores and state count
    logic [63:0] node_sets [NODE_COUNT_DEF];
    logic [23:0] site_sum;
    logic [31:0] total_sum;
    logic [6:0]  states_in_use;
    out_word_t   merges_due [$];

    initial mismatch_count = 0;
    initial results_due = 0;

    // low bits set for every state in use
    function automatic logic [63:0] state_mask(input logic [6:0] n);
        if (n == 7'd0) return '0;
        if (n >= 7'(MAX_STATES_DEF)) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // set of one child: leaf character or stored node
    function automatic logic [63:0] child_states(input logic leaf, input logic [6:0] ch,
                                                 input logic [7:0] idx,
                                                 input logic [63:0] mask);
        if (leaf) begin
            // gap code and anything beyond the alphabet mean every state
            if (ch >= states_in_use || ch >= 7'(MAX_STATES_DEF)) return mask;
            return 64'd1 << ch;
        end
        return node_sets[idx] & mask;
    endfunction

    // one fitch merge: intersect, else union and charge, update scores
    function automatic out_word_t fitch_merge(input in_word_t w);
        out_word_t   r;
        logic [63:0] mask;
        logic [63:0] lset;
        logic [63:0] rset;
        logic [63:0] merged;
        logic [15:0] cost;
        logic [24:0] site_next;
        logic [32:0] total_next;
        mask   = state_mask(states_in_use);
        lset   = child_states(w.left_is_leaf, w.left_char, w.left_node, mask);
        rset   = child_states(w.right_is_leaf, w.right_char, w.right_node, mask);
        merged = lset & rset;
        cost   = '0;
        if (merged == '0) begin
            merged = lset | rset;
            cost   = w.weight;
        end
        node_sets[w.dest_node] = merged;
        // both scores saturate
        site_next = {1'b0, site_sum} + cost;
        if (site_next > {1'b0, SITE_MAX}) site_next = {1'b0, SITE_MAX};
        total_next = {1'b0, total_sum} + cost;
        if (total_next > {1'b0, TOTAL_MAX}) total_next = {1'b0, TOTAL_MAX};
        site_sum  = site_next[23:0];
        total_sum = total_next[31:0];
        r.node_set    = merged;
        r.step_cost   = cost;
        r.site_score  = site_sum;
        r.total_score = total_sum;
        r.site_done   = w.site_end;
        // root merge closes the site
        if (w.site_end) site_sum = '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s expected %h got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            states_in_use = NUM_STATES_RESET;
            site_sum      = '0;
            total_sum     = '0;
            merges_due.delete();
        end else begin
            if (cfg_we) states_in_use = cfg_wdata;
            // returned word against the oldest prediction
            if (m_valid && m_ready) begin
                if (merges_due.size() == 0) begin
                    $error("result word with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = merges_due.pop_front();
                    check_field("node_set", want.node_set, m_word.node_set);
                    check_field("step_cost", 64'(want.step_cost), 64'(m_word.step_cost));
                    check_field("site_score", 64'(want.site_score), 64'(m_word.site_score));
                    check_field("total_score", 64'(want.total_score),
                                64'(m_word.total_score));
                    check_field("site_done", 64'(want.site_done), 64'(m_word.site_done));
                end
            end
            if (s_valid && s_ready) merges_due.push_back(fitch_merge(s_word));
        end
        results_due = merges_due.size();
    end

endmodule

### bench/fitch_parsimony_node_combine_tb.sv
`timescale 1ns / 100ps

module fitch_parsimony_node_combine_tb;
    import fpnc_pkg::*;

    typedef struct {
        logic       is_leaf;
        logic [6:0] ch;
        logic [7:0] idx;
    } subtree_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_word    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_word;

    int mismatch_count;
    int results_due;

    logic word_taken   = 1'b0;
    logic result_taken = 1'b0;
    int   send_calm    = 0;
    int   recv_calm    = 0;
    int   recv_gap     = 0;
    int   words_sent   = 0;
    bit   full_rate    = 1'b0;

    // nodes written so far, so that no unwritten entry is ever read
    bit         node_written [NODE_COUNT_DEF];
    logic [7:0] stored_nodes [$];
    logic [6:0] states_now = NUM_STATES_RESET;

    logic [6:0] state_plan [7] = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd1, 7'd33, 7'd64};

    always #5 aclk = ~aclk;

    fitch_parsimony_node_combine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    fitch_score_checker score_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word         (m_word),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // idle cycles before the next word, with calm stretches now and then
    function automatic int draw_gap(inout int calm);
        if (full_rate) return 0;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // mostly real states, some gaps, some out-of-range codes
    function automatic logic [6:0] draw_char();
        int cap;
        int r;
        cap = (states_now > 7'd64) ? 64 : int'(states_now);
        r   = $urandom_range(0, 9);
        if (r < 7 && cap > 0) return 7'($urandom_range(0, cap - 1));
        if (r < 9) return states_now;
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [15:0] draw_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 12));
    endfunction

    function automatic logic [7:0] pick_stored();
        return stored_nodes[$urandom_range(0, stored_nodes.size() - 1)];
    endfunction

    function automatic in_word_t make_word(input logic ll, input logic [6:0] lc,
                                           input logic [7:0] ln, input logic rl,
                                           input logic [6:0] rc, input logic [7:0] rn,
                                           input logic [7:0] dest, input logic [15:0] wt,
                                           input logic last);
        in_word_t w;
        w.left_is_leaf  = ll;
        w.left_char     = lc;
        w.left_node     = ln;
        w.right_is_leaf = rl;
        w.right_char    = rc;
        w.right_node    = rn;
        w.dest_node     = dest;
        w.weight        = wt;
        w.site_end      = last;
        return w;
    endfunction

    // handshake flags sampled at the rising edge
    always @(posedge aclk) begin
        word_taken   <= s_valid && s_ready;
        result_taken <= m_valid && m_ready;
    end

    // result side stalls
    always @(negedge aclk) begin
        if (result_taken) recv_gap = draw_gap(recv_calm);
        if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_word_t w);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        @(negedge aclk);
        while (!word_taken) @(negedge aclk);
        if (!node_written[w.dest_node]) begin
            node_written[w.dest_node] = 1'b1;
            stored_nodes.push_back(w.dest_node);
        end
        words_sent++;
    endtask

    // post-order merges of one random tree, root merge last
    task automatic run_site(input int leaves);
        subtree_t pool [$];
        subtree_t a;
        subtree_t b;
        subtree_t made;
        in_word_t w;
        int       i;
        for (int k = 0; k < leaves; k++) begin
            made.is_leaf = 1'b1;
            made.ch      = draw_char();
            made.idx     = 8'($urandom_range(0, 255));
            // now and then a subtree that is already stored
            if (stored_nodes.size() != 0 && $urandom_range(0, 3) == 0) begin
                made.is_leaf = 1'b0;
                made.idx     = pick_stored();
            end
            pool.push_back(made);
        end
        while (pool.size() > 1) begin
            i = $urandom_range(0, pool.size() - 1);
            a = pool[i];
            pool.delete(i);
            i = $urandom_range(0, pool.size() - 1);
            b = pool[i];
            pool.delete(i);
            w = make_word(a.is_leaf, a.is_leaf ? a.ch : 7'($urandom_range(0, 127)), a.idx,
                          b.is_leaf, b.is_leaf ? b.ch : 7'($urandom_range(0, 127)), b.idx,
                          8'($urandom_range(0, 255)), draw_weight(), pool.size() == 0);
            send_word(w);
            made.is_leaf = 1'b0;
            made.ch      = 7'($urandom_range(0, 127));
            made.idx     = w.dest_node;
            pool.push_back(made);
        end
    endtask

    // loose word with random fields, reading only written nodes
    task automatic send_noise();
        in_word_t w;
        w = make_word(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), draw_weight(), $urandom_range(0, 7) == 0);
        if (!w.left_is_leaf) begin
            if (stored_nodes.size() == 0) w.left_is_leaf = 1'b1;
            else w.left_node = pick_stored();
        end
        if (!w.right_is_leaf) begin
            if (stored_nodes.size() == 0) w.right_is_leaf = 1'b1;
            else w.right_node = pick_stored();
        end
        send_word(w);
    endtask

    task automatic run_phase(input int words);
        int first;
        first = words_sent;
        while (words_sent - first < words) begin
            if ($urandom_range(0, 4) != 0) run_site($urandom_range(2, 9));
            else send_noise();
        end
    endtask

    // drain, let the pipeline settle, then write the state count
    task automatic set_states(input logic [6:0] v);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        states_now = v;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words at the reset state count of four
        send_word(make_word(1, 7'd0, 8'd0, 1, 7'd0, 8'd0, 8'd0, 16'hFFFF, 0));
        send_word(make_word(1, 7'd1, 8'd255, 1, 7'd2, 8'd255, 8'd255, 16'hFFFF, 0));
        send_word(make_word(1, 7'd4, 8'd0, 1, 7'd3, 8'd0, 8'd1, 16'd1, 0));
        send_word(make_word(1, 7'd127, 8'd0, 1, 7'd64, 8'd0, 8'd2, 16'd5, 0));
        send_word(make_word(0, 7'd0, 8'd0, 0, 7'd0, 8'd255, 8'd3, 16'd7, 0));
        send_word(make_word(0, 7'd127, 8'd3, 1, 7'd3, 8'd0, 8'd4, 16'd0, 0));
        send_word(make_word(0, 7'd0, 8'd4, 0, 7'd0, 8'd4, 8'd4, 16'd3, 0));
        send_word(make_word(0, 7'd0, 8'd2, 0, 7'd0, 8'd1, 8'd5, 16'd9, 1));
        send_word(make_word(1, 7'd3, 8'd0, 1, 7'd3, 8'd0, 8'd6, 16'd2, 1));
        send_word(make_word(0, 7'd0, 8'd6, 0, 7'd0, 8'd4, 8'd7, 16'h8000, 0));
        send_word(make_word(0, 7'd0, 8'd255, 0, 7'd0, 8'd0, 8'd8, 16'd1, 1));
        run_phase(75);

        // extremes and odd state counts
        foreach (state_plan[p]) begin
            set_states(state_plan[p]);
            run_phase(75);
        end

        // back-to-back conflicting words at top weight drive the site score to saturation
        set_states(7'd64);
        full_rate = 1'b1;
        for (int k = 0; k < 300; k++) begin
            send_word(make_word(1, 7'd0, 8'd0, 1, 7'd1, 8'd0, 8'(k), 16'hFFFF,
                                (k % 300) == 299));
        end
        full_rate = 1'b0;

        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
